@@ design/hmh_pkg.sv @@
package hmh_pkg;

    // Array geometry.
    localparam int FIBERS_PER_LAYER = 16;
    localparam int COUNT_WIDTH      = 32;

    localparam int NSTORE  = 4 * FIBERS_PER_LAYER;
    localparam int NBINS   = 2 * FIBERS_PER_LAYER + 1;
    localparam int NHIST   = NBINS * NBINS;
    localparam int FIB_W   = $clog2(FIBERS_PER_LAYER);
    localparam int LOW_W   = FIB_W + 1;
    localparam int SIDX_W  = $clog2(NSTORE);
    localparam int BIN_W   = $clog2(NBINS);
    localparam int HADDR_W = $clog2(NHIST);

    // Function codes of an input transaction.
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    // Kind codes of a result transaction.
    localparam logic KIND_DECISION = 1'b0;
    localparam logic KIND_READBACK = 1'b1;

    // Unity gain in unsigned Q4.12.
    localparam logic [15:0] GAIN_ONE = 16'd4096;

    typedef struct packed {
        logic [1:0]         func;
        logic               layer;
        logic               axis;
        logic [3:0]         fiber;
        logic signed [23:0] sample_value;
        logic signed [23:0] threshold;
        logic [15:0]        gain_recip;
        logic               last_of_event;
        logic [5:0]         bin_x;
        logic [5:0]         bin_y;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic        filled;
        logic [4:0]  x_low_bin;
        logic [4:0]  y_low_bin;
        logic [31:0] bin_count;
    } t_out_item;

    // Write side of the fiber store.
    typedef struct packed {
        logic               cal_we;
        logic               raw_we;
        logic               raw_clr;
        logic [SIDX_W-1:0]  idx;
        logic signed [23:0] thr;
        logic [15:0]        gain;
        logic signed [23:0] raw;
    } t_store_wr;

    // Registered read data of the fiber store, defaults already applied.
    typedef struct packed {
        logic signed [23:0] thr;
        logic [15:0]        gain;
        logic signed [23:0] raw;
    } t_store_rd;

    // Command to the histogram memory.
    typedef struct packed {
        logic               rd_en;
        logic               bump_en;
        logic [HADDR_W-1:0] addr;
    } t_hist_cmd;

    function automatic logic [SIDX_W-1:0] store_index(
        input logic             axis,
        input logic             layer,
        input logic [FIB_W-1:0] fib
    );
        int sum;
        sum = (axis ? 2 * FIBERS_PER_LAYER : 0) + (layer ? FIBERS_PER_LAYER : 0) + int'(fib);
        return SIDX_W'(sum);
    endfunction

    function automatic logic [HADDR_W-1:0] hist_addr(
        input logic [BIN_W-1:0] x,
        input logic [BIN_W-1:0] y
    );
        int sum;
        sum = int'(x) * NBINS + int'(y);
        return HADDR_W'(sum);
    endfunction

endpackage

@@ design/hmh_fiber_store.sv @@
module hmh_fiber_store
    import hmh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_store_wr         i_wr,
    input  logic              i_rd_en,
    input  logic [SIDX_W-1:0] i_rd_idx,
    output t_store_rd         o_rd
);

    logic signed [23:0] r_thr_mem  [NSTORE];
    logic [15:0]        r_gain_mem [NSTORE];
    logic signed [23:0] r_raw_mem  [NSTORE];

    // An entry whose valid bit is clear reads as its reset value.
    logic [NSTORE-1:0]  r_cal_vld;
    logic [NSTORE-1:0]  r_raw_vld;

    logic signed [23:0] r_rd_thr;
    logic [15:0]        r_rd_gain;
    logic signed [23:0] r_rd_raw;
    logic               r_rd_cal_vld;
    logic               r_rd_raw_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.cal_we) begin
            r_thr_mem[i_wr.idx]  <= i_wr.thr;
            r_gain_mem[i_wr.idx] <= i_wr.gain;
        end
        if (i_wr.raw_we) begin
            r_raw_mem[i_wr.idx] <= i_wr.raw;
        end
        if (i_rd_en) begin
            r_rd_thr     <= r_thr_mem[i_rd_idx];
            r_rd_gain    <= r_gain_mem[i_rd_idx];
            r_rd_raw     <= r_raw_mem[i_rd_idx];
            r_rd_cal_vld <= r_cal_vld[i_rd_idx];
            r_rd_raw_vld <= r_raw_vld[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_vld <= '0;
            r_raw_vld <= '0;
        end else begin
            if (i_wr.cal_we) begin
                r_cal_vld[i_wr.idx] <= 1'b1;
            end
            if (i_wr.raw_clr) begin
                r_raw_vld <= '0;
            end else if (i_wr.raw_we) begin
                r_raw_vld[i_wr.idx] <= 1'b1;
            end
        end
    end

    assign o_rd.thr  = r_rd_cal_vld ? r_rd_thr  : '0;
    assign o_rd.gain = r_rd_cal_vld ? r_rd_gain : GAIN_ONE;
    assign o_rd.raw  = r_rd_raw_vld ? r_rd_raw  : '0;

endmodule

@@ design/hmh_histogram.sv @@
module hmh_histogram
    import hmh_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_hist_cmd              i_cmd,
    output logic                   o_clearing,
    output logic [COUNT_WIDTH-1:0] o_rd_data
);

    logic [COUNT_WIDTH-1:0] r_mem [NHIST];
    logic [COUNT_WIDTH-1:0] r_rd_data;

    logic                   r_clr_busy;
    logic [HADDR_W-1:0]     r_clr_addr;
    logic                   r_pend_bump;
    logic [HADDR_W-1:0]     r_pend_addr;

    logic                   wr_en;
    logic [HADDR_W-1:0]     wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;
    logic [COUNT_WIDTH-1:0] sat_inc;

    // A bump reads the counter, then writes it back in the next cycle.
    assign sat_inc = (r_rd_data == '1) ? r_rd_data : r_rd_data + 1'b1;
    assign wr_en   = r_clr_busy || r_pend_bump;
    assign wr_addr = r_clr_busy ? r_clr_addr : r_pend_addr;
    assign wr_data = r_clr_busy ? '0 : sat_inc;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en || i_cmd.bump_en) begin
            r_rd_data <= r_mem[i_cmd.addr];
        end
        r_pend_addr <= i_cmd.addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_pend_bump <= 1'b0;
        end else begin
            r_pend_bump <= i_cmd.bump_en;
            if (r_clr_busy) begin
                if (r_clr_addr == HADDR_W'(NHIST - 1)) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    assign o_clearing = r_clr_busy;
    assign o_rd_data  = r_rd_data;

    // No command may arrive while the memory is being cleared.
    a_no_cmd_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !(i_cmd.rd_en || i_cmd.bump_en))
        else $error("histogram command during clearing pass");

    // A read must never hit the counter whose write-back is still in flight.
    a_no_rmw_hazard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_bump && (i_cmd.rd_en || i_cmd.bump_en) |-> i_cmd.addr != r_pend_addr)
        else $error("histogram read collides with pending write-back");

endmodule

@@ design/hodoscope_max_hit_histogrammer_top.sv @@
// Channel   Direction  Handshake                     Payload
// input     in         i_in_valid / o_in_stall       i_in_data   (t_in_item)
// result    out        o_out_valid / i_out_stall     o_out_data  (t_out_item)
//
// Loads and unmarked samples leave the sequencer idle; a read steps through read and
// emit, or straight to emit off the grid. A last sample steps through accept, 64 fiber
// reads through the shared unit, drain, decide, four histogram bumps and emit; with no
// fill the bumps are skipped. After reset the input stalls while the histogram clears.
// A stalled result waits in the output register; transactions without a result still
// flow, and the next result-producing transaction stalls the input in its emit step.
module hodoscope_max_hit_histogrammer_top
    import hmh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    // The sequencer walks the store once per event, one fiber per cycle.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_BUMP,
        S_READ,
        S_EMIT
    } t_state;

    // Identity of the fiber that travels down the scan pipeline.
    typedef struct packed {
        logic             vld;
        logic             axis;
        logic             layer;
        logic [FIB_W-1:0] fiber;
        logic             first;
        logic             last;
    } t_scan_tag;

    t_state             r_state,     n_state;
    logic               r_sc_axis,   n_sc_axis;
    logic               r_sc_layer,  n_sc_layer;
    logic [FIB_W-1:0]   r_sc_fib,    n_sc_fib;
    logic [1:0]         r_bump_cnt,  n_bump_cnt;
    t_out_item          r_res,       n_res;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_data,  n_out_data;

    // Scan pipeline: stage one is the registered store read, stage two the
    // registered product, and the running best is updated behind stage two.
    t_scan_tag          r_s1;
    t_scan_tag          r_s2;
    logic               r_s2_hit;
    logic signed [39:0] r_s2_prod;
    logic               r_have,  n_have;
    logic signed [39:0] r_best,  n_best;
    logic [LOW_W-1:0]   r_low,   n_low;
    logic               r_x_have;
    logic [LOW_W-1:0]   r_x_low;
    logic               r_y_have;
    logic [LOW_W-1:0]   r_y_low;

    t_store_wr          store_wr;
    t_store_rd          store_rd;
    logic               store_rd_en;
    logic [SIDX_W-1:0]  store_rd_idx;
    t_hist_cmd          hist_cmd;
    logic               hist_clearing;
    logic [COUNT_WIDTH-1:0] hist_rd_data;

    logic               in_acc;
    logic               fok;
    logic               bin_ok;
    logic [HADDR_W-1:0] rd_addr;
    logic [HADDR_W-1:0] bump_addr;
    t_scan_tag          scan_tag;
    logic               s1_hit;
    logic signed [40:0] s1_prod;
    logic               cur_have;
    logic               take;

    hmh_fiber_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (store_wr),
        .i_rd_en  (store_rd_en),
        .i_rd_idx (store_rd_idx),
        .o_rd     (store_rd)
    );

    hmh_histogram u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (hist_cmd),
        .o_clearing (hist_clearing),
        .o_rd_data  (hist_rd_data)
    );

    // Input transactions are taken only while the sequencer is idle.
    assign o_in_stall  = (r_state != S_IDLE) || hist_clearing;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Fibers past the end of a layer store nothing; bins past the grid read as zero.
    assign fok    = 32'(i_in_data.fiber) < 32'(FIBERS_PER_LAYER);
    assign bin_ok = (32'(i_in_data.bin_x) < 32'(NBINS)) && (32'(i_in_data.bin_y) < 32'(NBINS));
    assign rd_addr = hist_addr(BIN_W'(i_in_data.bin_x), BIN_W'(i_in_data.bin_y));

    // The four footprint bins are walked with bit one stepping X and bit zero Y.
    assign bump_addr = hist_addr(BIN_W'(r_x_low) + BIN_W'(r_bump_cnt[1]),
                                 BIN_W'(r_y_low) + BIN_W'(r_bump_cnt[0]));

    assign store_rd_idx   = store_index(r_sc_axis, r_sc_layer, r_sc_fib);
    assign scan_tag.vld   = (r_state == S_SCAN);
    assign scan_tag.axis  = r_sc_axis;
    assign scan_tag.layer = r_sc_layer;
    assign scan_tag.fiber = r_sc_fib;
    assign scan_tag.first = !r_sc_layer && (r_sc_fib == '0);
    assign scan_tag.last  = r_sc_layer && (r_sc_fib == FIB_W'(FIBERS_PER_LAYER - 1));

    // The shared unit: threshold compare and the raw times gain product.
    assign s1_hit  = $signed(store_rd.raw) > $signed(store_rd.thr);
    assign s1_prod = $signed(store_rd.raw) * $signed({1'b0, store_rd.gain});

    // Only a strictly larger product replaces the current winner, so ties stay
    // with the earlier fiber in scan order. The first fiber of an axis starts over.
    always_comb begin
        cur_have = r_s2.first ? 1'b0 : r_have;
        take     = r_s2.vld && r_s2_hit && (!cur_have || (r_s2_prod > r_best));
        n_have   = r_have;
        n_best   = r_best;
        n_low    = r_low;
        if (r_s2.vld) begin
            n_have = cur_have || take;
        end
        if (take) begin
            n_best = r_s2_prod;
            n_low  = {r_s2.fiber, r_s2.layer};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1.axis  <= scan_tag.axis;
        r_s1.layer <= scan_tag.layer;
        r_s1.fiber <= scan_tag.fiber;
        r_s1.first <= scan_tag.first;
        r_s1.last  <= scan_tag.last;
        r_s2.axis  <= r_s1.axis;
        r_s2.layer <= r_s1.layer;
        r_s2.fiber <= r_s1.fiber;
        r_s2.first <= r_s1.first;
        r_s2.last  <= r_s1.last;
        r_s2_hit   <= s1_hit;
        r_s2_prod  <= s1_prod[39:0];
        r_best     <= n_best;
        r_low      <= n_low;
        if (r_s2.vld && r_s2.last && !r_s2.axis) begin
            r_x_low <= n_low;
        end
        if (r_s2.vld && r_s2.last && r_s2.axis) begin
            r_y_low <= n_low;
        end
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_s2.vld <= 1'b0;
            r_have   <= 1'b0;
            r_x_have <= 1'b0;
            r_y_have <= 1'b0;
        end else begin
            r_s1.vld <= scan_tag.vld;
            r_s2.vld <= r_s1.vld;
            r_have   <= n_have;
            if (r_s2.vld && r_s2.last && !r_s2.axis) begin
                r_x_have <= n_have;
            end
            if (r_s2.vld && r_s2.last && r_s2.axis) begin
                r_y_have <= n_have;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sc_axis   = r_sc_axis;
        n_sc_layer  = r_sc_layer;
        n_sc_fib    = r_sc_fib;
        n_bump_cnt  = r_bump_cnt;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        store_wr.cal_we  = 1'b0;
        store_wr.raw_we  = 1'b0;
        store_wr.raw_clr = 1'b0;
        store_wr.idx     = store_index(i_in_data.axis, i_in_data.layer,
                                       FIB_W'(i_in_data.fiber));
        store_wr.thr     = i_in_data.threshold;
        store_wr.gain    = i_in_data.gain_recip;
        store_wr.raw     = i_in_data.sample_value;
        store_rd_en      = 1'b0;
        hist_cmd.rd_en   = 1'b0;
        hist_cmd.bump_en = 1'b0;
        hist_cmd.addr    = rd_addr;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.func)
                        FUNC_LOAD: begin
                            store_wr.cal_we = fok;
                        end
                        FUNC_SAMPLE: begin
                            store_wr.raw_we = fok;
                            if (i_in_data.last_of_event) begin
                                n_sc_axis  = 1'b0;
                                n_sc_layer = 1'b0;
                                n_sc_fib   = '0;
                                n_state    = S_SCAN;
                            end
                        end
                        FUNC_READ: begin
                            if (bin_ok) begin
                                hist_cmd.rd_en = 1'b1;
                                n_state        = S_READ;
                            end else begin
                                n_res.kind      = KIND_READBACK;
                                n_res.filled    = 1'b0;
                                n_res.x_low_bin = '0;
                                n_res.y_low_bin = '0;
                                n_res.bin_count = '0;
                                n_state         = S_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                store_rd_en = 1'b1;
                if (r_sc_fib == FIB_W'(FIBERS_PER_LAYER - 1)) begin
                    n_sc_fib = '0;
                    if (r_sc_layer) begin
                        n_sc_layer = 1'b0;
                        if (r_sc_axis) begin
                            // The last read has sampled the store; raw values are done.
                            store_wr.raw_clr = 1'b1;
                            n_state          = S_DRAIN;
                        end else begin
                            n_sc_axis = 1'b1;
                        end
                    end else begin
                        n_sc_layer = 1'b1;
                    end
                end else begin
                    n_sc_fib = r_sc_fib + 1'b1;
                end
            end
            S_DRAIN: begin
                if (r_s2.vld && r_s2.last && r_s2.axis) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_res.kind      = KIND_DECISION;
                n_res.bin_count = '0;
                if (r_x_have && r_y_have) begin
                    n_res.filled    = 1'b1;
                    n_res.x_low_bin = 5'(r_x_low);
                    n_res.y_low_bin = 5'(r_y_low);
                    n_bump_cnt      = '0;
                    n_state         = S_BUMP;
                end else begin
                    n_res.filled    = 1'b0;
                    n_res.x_low_bin = '0;
                    n_res.y_low_bin = '0;
                    n_state         = S_EMIT;
                end
            end
            S_BUMP: begin
                hist_cmd.bump_en = 1'b1;
                hist_cmd.addr    = bump_addr;
                n_bump_cnt       = r_bump_cnt + 1'b1;
                if (r_bump_cnt == 2'd3) begin
                    n_state = S_EMIT;
                end
            end
            S_READ: begin
                n_res.kind      = KIND_READBACK;
                n_res.filled    = 1'b0;
                n_res.x_low_bin = '0;
                n_res.y_low_bin = '0;
                n_res.bin_count = 32'(hist_rd_data);
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_sc_axis  <= n_sc_axis;
        r_sc_layer <= n_sc_layer;
        r_sc_fib   <= n_sc_fib;
        r_bump_cnt <= n_bump_cnt;
        r_res      <= n_res;
        r_out_data <= n_out_data;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // The Y axis result lands exactly when the sequencer moves to the decision.
    a_scan_to_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2.vld && r_s2.last && r_s2.axis |=> r_state == S_DECIDE)
        else $error("scan end did not reach the decision step");

    // The histogram is bumped only when both axes found a winner.
    a_bump_needs_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hist_cmd.bump_en |-> r_x_have && r_y_have)
        else $error("histogram bumped without two winners");

    // No load or sample is written to the store while the scan is reading it.
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> !store_wr.cal_we && !store_wr.raw_we)
        else $error("fiber store written during scan");

endmodule
